>>> rtl/core/ssdl_pkg.sv
`default_nettype none

package ssdl_pkg;

  localparam int CAPACITY = 32;
  localparam int SEQ_W    = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DRAIN  = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_DRAINED  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_RESP,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic             func;
    logic [SEQ_W-1:0] seq_in;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [SEQ_W-1:0] seq_out;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } cmp_res_t;

endpackage

`default_nettype wire

>>> rtl/core/sorted_sequence_drop_list_top.sv
`default_nettype none

// channel | ports                         | payload
// input   | in_valid, in_ready, in_data   | ssdl_pkg::in_item_t  {func, seq_in}
// output  | out_valid, out_ready, out_data| ssdl_pkg::out_item_t {status, seq_out, last}
//
// Insert: the ordered scan reads one entry per cycle through the single read port,
//   then later entries shift up one place and the new number is written.
// Drain: one entry per cycle while the output is not stalled; empty answers ST_EMPTY.
// Reset clears both counts; the entry store is not cleared.
// in_ready is high only while idle; a result waits in the output register.
module sorted_sequence_drop_list_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ssdl_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ssdl_pkg::out_item_t      out_data
);

  localparam int AW  = ssdl_pkg::ADDR_W;
  localparam int CW  = ssdl_pkg::CNT_W;
  localparam int SW  = ssdl_pkg::SEQ_W;
  localparam int CAP = ssdl_pkg::CAPACITY;

  logic [SW-1:0] mem [CAP];

  ssdl_pkg::state_t    state_r, state_nxt;
  logic [SW-1:0]       seq_r, seq_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       slots_r, slots_nxt;
  ssdl_pkg::status_t   status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  ssdl_pkg::out_item_t out_data_r, out_data_nxt;

  logic [SW-1:0] rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_data;

  logic               slot_free;
  logic               load;
  logic               drain_last;
  logic [SW-1:0]      cmp_a, cmp_b;
  ssdl_pkg::cmp_res_t cmp;

  // head uses "not after", later entries use "before"
  always_comb begin
    if (idx_r == '0) begin
      cmp_a = rd_data_r;
      cmp_b = seq_r;
    end else begin
      cmp_a = seq_r;
      cmp_b = rd_data_r;
    end
  end

  ssdl_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  assign slot_free  = !out_valid_r || out_ready;
  assign drain_last = (CW'(idx_r) + CW'(1)) == cnt_r;
  assign in_ready   = (state_r == ssdl_pkg::S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    state_nxt    = state_r;
    seq_nxt      = seq_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    slots_nxt    = slots_r;
    status_nxt   = status_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = seq_r;
    load         = 1'b0;
    out_data_nxt = out_data_r;

    case (state_r)
      ssdl_pkg::S_IDLE: begin
        if (in_valid) begin
          seq_nxt = in_data.seq_in;
          idx_nxt = '0;
          if (in_data.func == ssdl_pkg::FUNC_INSERT) begin
            if (slots_r >= CW'(CAP)) begin
              status_nxt = ssdl_pkg::ST_FULL;
              state_nxt  = ssdl_pkg::S_RESP;
            end else if (cnt_r == '0) begin
              pos_nxt   = '0;
              state_nxt = ssdl_pkg::S_PLACE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = ssdl_pkg::S_SCAN;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = ssdl_pkg::ST_EMPTY;
              slots_nxt  = '0;
              state_nxt  = ssdl_pkg::S_RESP;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = ssdl_pkg::S_DRAIN;
            end
          end
        end
      end

      ssdl_pkg::S_SCAN: begin
        if (cmp.zero) begin
          status_nxt = ssdl_pkg::ST_DUP;
          slots_nxt  = slots_r + CW'(1);
          state_nxt  = ssdl_pkg::S_RESP;
        end else if ((idx_r == '0) ? !cmp.neg : cmp.neg) begin
          pos_nxt   = idx_r;
          rd_en     = 1'b1;
          rd_addr   = AW'(cnt_r - CW'(1));
          idx_nxt   = cnt_r[AW-1:0];
          state_nxt = ssdl_pkg::S_SHIFT;
        end else if ((CW'(idx_r) + CW'(1)) >= cnt_r) begin
          pos_nxt   = cnt_r[AW-1:0];
          state_nxt = ssdl_pkg::S_PLACE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r + AW'(1);
          idx_nxt = idx_r + AW'(1);
        end
      end

      ssdl_pkg::S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data_r;
        if ((idx_r - AW'(1)) == pos_r) begin
          state_nxt = ssdl_pkg::S_PLACE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r - AW'(2);
          idx_nxt = idx_r - AW'(1);
        end
      end

      ssdl_pkg::S_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = pos_r;
        wr_data    = seq_r;
        cnt_nxt    = cnt_r + CW'(1);
        slots_nxt  = slots_r + CW'(1);
        status_nxt = ssdl_pkg::ST_INSERTED;
        state_nxt  = ssdl_pkg::S_RESP;
      end

      ssdl_pkg::S_RESP: begin
        if (slot_free) begin
          load                 = 1'b1;
          out_data_nxt.status  = status_r;
          out_data_nxt.seq_out = '0;
          out_data_nxt.last    = 1'b1;
          state_nxt            = ssdl_pkg::S_IDLE;
        end
      end

      ssdl_pkg::S_DRAIN: begin
        if (slot_free) begin
          load                 = 1'b1;
          out_data_nxt.status  = ssdl_pkg::ST_DRAINED;
          out_data_nxt.seq_out = rd_data_r;
          out_data_nxt.last    = drain_last;
          if (drain_last) begin
            cnt_nxt   = '0;
            slots_nxt = '0;
            state_nxt = ssdl_pkg::S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
            idx_nxt = idx_r + AW'(1);
          end
        end
      end

      default: begin
        state_nxt = ssdl_pkg::S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssdl_pkg::S_IDLE;
      cnt_r       <= '0;
      slots_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      slots_r     <= slots_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r      <= seq_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  a_cnt_le_slots: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= slots_r)
    else $error("distinct count exceeds used slots");

  a_slots_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    slots_r <= CW'(CAP))
    else $error("used slots exceed capacity");

  a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ssdl_pkg::S_SHIFT) |-> (idx_r > pos_r))
    else $error("shift write below insert position");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.func == ssdl_pkg::FUNC_INSERT)
     && (slots_r == CW'(CAP)))
    |=> (state_r == ssdl_pkg::S_RESP) && $stable(cnt_r) && $stable(slots_r))
    else $error("full insert changed state");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ssdl_pkg::S_DRAIN) && slot_free && drain_last)
    |=> (cnt_r == '0) && (slots_r == '0) && out_valid_r && out_data_r.last)
    else $error("drain end did not clear list");

endmodule

`default_nettype wire

>>> rtl/core/ssdl_cmp.sv
`default_nettype none

// shared serial-number compare: sign and zero of a - b
module ssdl_cmp (
  input  wire logic [ssdl_pkg::SEQ_W-1:0] a,
  input  wire logic [ssdl_pkg::SEQ_W-1:0] b,
  output ssdl_pkg::cmp_res_t              res
);

  logic [ssdl_pkg::SEQ_W-1:0] diff;

  assign diff     = a - b;
  assign res.neg  = diff[ssdl_pkg::SEQ_W-1];
  assign res.zero = (diff == '0);

endmodule

`default_nettype wire

>>> tb/tb_sorted_sequence_drop_list_top.sv
`timescale 1ns / 1ps

module tb_sorted_sequence_drop_list_top;
  import ssdl_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;
  localparam int RANDOM_ITEMS  = 255;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic [SEQ_W-1:0] drop_list [CAPACITY];
  int unsigned      drop_count = 0;
  int unsigned      slot_count = 0;
  out_item_t        expected_results [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          steady_flow    = 1'b0;

  sorted_sequence_drop_list_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // serial-number order: a after b when (b - a) is negative
  function automatic bit seq_is_after(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = b - a;
    return d[SEQ_W-1];
  endfunction

  function automatic bit seq_is_before(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return d[SEQ_W-1];
  endfunction

  function automatic void push_result(status_t st, logic [SEQ_W-1:0] seq, logic lst);
    out_item_t r;
    r.status  = st;
    r.seq_out = seq;
    r.last    = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void list_place(int unsigned pos, logic [SEQ_W-1:0] seq);
    for (int unsigned j = drop_count; j > pos; j--)
      drop_list[j] = drop_list[j-1];
    drop_list[pos] = seq;
    drop_count++;
  endfunction

  function automatic status_t list_insert(logic [SEQ_W-1:0] seq);
    int unsigned pos;
    int unsigned j;
    bit          dup;
    bit          searching;
    pos = 0;
    dup = 1'b0;
    if (drop_count != 0) begin
      if (seq == drop_list[0]) begin
        dup = 1'b1;
      end else if (seq_is_after(seq, drop_list[0])) begin
        j = 0;
        pos = drop_count;
        searching = 1'b1;
        while (searching) begin
          if (j + 1 >= drop_count) begin
            searching = 1'b0;
          end else if (seq_is_before(seq, drop_list[j+1])) begin
            pos = j + 1;
            searching = 1'b0;
          end else begin
            j++;
            if (seq == drop_list[j]) begin
              dup = 1'b1;
              searching = 1'b0;
            end
          end
        end
      end
    end
    if (dup)
      return ST_DUP;
    list_place(pos, seq);
    return ST_INSERTED;
  endfunction

  function automatic void predict_item(in_item_t it);
    if (it.func == FUNC_INSERT) begin
      if (slot_count >= CAPACITY) begin
        push_result(ST_FULL, '0, 1'b1);
      end else begin
        push_result(list_insert(it.seq_in), '0, 1'b1);
        slot_count++;
      end
    end else if (drop_count == 0) begin
      push_result(ST_EMPTY, '0, 1'b1);
      slot_count = 0;
    end else begin
      for (int unsigned i = 0; i < drop_count; i++)
        push_result(ST_DRAINED, drop_list[i], (i + 1 == drop_count));
      drop_count = 0;
      slot_count = 0;
    end
  endfunction

  function automatic void note_mismatch(string what, out_item_t want, out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: expected status=%0d seq=%h last=%0d, got status=%0d seq=%h last=%0d",
               $time, what, want.status, want.seq_out, want.last,
               got.status, got.seq_out, got.last);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      predict_item(in_data);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result with nothing pending", '0, out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status || out_data.seq_out !== want.seq_out ||
            out_data.last !== want.last)
          note_mismatch("result mismatch", want, out_data);
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= steady_flow || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(logic f, logic [SEQ_W-1:0] seq);
    in_item_t    it;
    int unsigned gap;
    it.func   = f;
    it.seq_in = seq;
    if (!steady_flow && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_empty_drain();
    send_item(FUNC_DRAIN, 32'hFFFF_FFFF);
    send_item(FUNC_DRAIN, 32'h0000_0000);
    wait_for_results();
  endtask

  task automatic test_extremes();
    send_item(FUNC_INSERT, 32'h0000_0000);
    send_item(FUNC_INSERT, 32'hFFFF_FFFF);
    send_item(FUNC_INSERT, 32'h0000_0000);
    send_item(FUNC_INSERT, 32'h8000_0000);
    send_item(FUNC_INSERT, 32'h7FFF_FFFF);
    send_item(FUNC_INSERT, 32'h0000_0001);
    send_item(FUNC_INSERT, 32'h7FFF_FFFF);
    send_item(FUNC_INSERT, 32'h8000_0001);
    send_item(FUNC_INSERT, 32'hFFFF_FFFE);
    send_item(FUNC_INSERT, 32'hFFFF_FFFE);
    send_item(FUNC_DRAIN, 32'h0000_0000);
    send_item(FUNC_INSERT, 32'h1234_5678);
    send_item(FUNC_DRAIN, 32'hFFFF_FFFF);
    send_item(FUNC_DRAIN, 32'h0000_0000);
    wait_for_results();
  endtask

  // duplicates also take slots, so the list fills before it holds CAPACITY numbers
  task automatic test_full_list();
    logic [SEQ_W-1:0] base;
    base = $urandom();
    for (int i = 0; i < 20; i++)
      send_item(FUNC_INSERT, base + 32'(i * 3));
    for (int i = 0; i < CAPACITY - 20; i++)
      send_item(FUNC_INSERT, base + 32'($urandom_range(0, 19) * 3));
    send_item(FUNC_INSERT, base + 32'd1);
    send_item(FUNC_INSERT, base);
    send_item(FUNC_INSERT, ~base);
    send_item(FUNC_DRAIN, '0);
    send_item(FUNC_INSERT, base);
    send_item(FUNC_DRAIN, '0);
    wait_for_results();
  endtask

  task automatic test_random_sequences();
    int unsigned      sent;
    int unsigned      mode;
    int unsigned      len;
    int unsigned      spread;
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] seq;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steady_flow = (sent >= 80 && sent < 140);
      mode = $urandom_range(0, 9);
      if (mode <= 6) begin
        len    = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 12);
        spread = $urandom_range(0, 2);
        base   = $urandom();
        for (int unsigned k = 0; k < len; k++) begin
          case (spread)
            0:       seq = base + 32'($urandom_range(0, 47));
            1:       seq = $urandom();
            default: seq = base + {2'($urandom_range(0, 3)), 30'd0} + 32'($urandom_range(0, 7));
          endcase
          send_item(FUNC_INSERT, seq);
        end
        send_item(FUNC_DRAIN, $urandom());
        sent += len + 1;
      end else if (mode <= 8) begin
        send_item(1'($urandom_range(0, 1)), $urandom());
        sent++;
      end else begin
        send_item(FUNC_DRAIN, $urandom());
        sent++;
      end
      if ($urandom_range(0, 15) == 0)
        wait_for_results();
    end
    steady_flow = 1'b0;
    wait_for_results();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_drain();
    test_extremes();
    test_full_list();
    test_random_sequences();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
